// File: hw/rtl/cobs_frame_decoder_unit_assert.svh
// Assertion macros shared by the decoder.
`ifndef COBS_FRAME_DECODER_UNIT_ASSERT_SVH
`define COBS_FRAME_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CFD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("decoder check failed");

// Next-cycle implication, checked outside reset.
`define CFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("decoder check failed");

`endif

// File: hw/rtl/cfd_pkg.sv
package cfd_pkg;

   localparam int unsigned ByteW = 8;
   localparam logic [ByteW-1:0] DelimByte = 8'h00;

   typedef struct packed {
      logic             valid;
      logic [ByteW-1:0] in_byte;
   } cfd_item_type;

   typedef struct packed {
      logic [ByteW-1:0] out_byte;
      logic             frame_end;
      logic [ByteW-1:0] frame_length;
      logic             overflow;
   } cfd_result_type;

   typedef struct packed {
      logic           valid;
      cfd_result_type data;
   } cfd_step_out_type;

endpackage

// File: hw/rtl/cfd_if.sv
interface cfd_req_if import cfd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface cfd_rsp_if import cfd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] out_byte;
   logic             frame_end;
   logic [ByteW-1:0] frame_length;
   logic             overflow;

   modport source (output valid, output out_byte, output frame_end, output frame_length,
                   output overflow, input ready);
   modport sink (input valid, input out_byte, input frame_end, input frame_length,
                 input overflow, output ready);
endinterface

// File: hw/rtl/cfd_in_stage.sv
module cfd_in_stage import cfd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [ByteW-1:0] req_in_byte,
   output logic             req_ready,
   input  logic             take,
   output cfd_item_type     item
);

   logic             valid_ff;
   logic             valid_in;
   logic [ByteW-1:0] byte_ff;

   // The held byte leaves on take, so a new one may enter in the same cycle.
   assign req_ready = !valid_ff || take;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         byte_ff <= req_in_byte;
      end
   end

   assign item.valid   = valid_ff;
   assign item.in_byte = byte_ff;

endmodule

// File: hw/rtl/cfd_step.sv
module cfd_step import cfd_pkg::*; #(
   parameter int unsigned MAX_LEN = 254
) (
   input  logic             clock,
   input  logic             reset,
   input  cfd_item_type     item,
   input  logic             out_free,
   output logic             take,
   output cfd_step_out_type step_out
);

   localparam logic [ByteW-1:0] MaxLenB = ByteW'(MAX_LEN);

   logic             in_frame_ff, in_frame_in;
   logic [ByteW-1:0] run_count_ff, run_count_in;
   logic [ByteW-1:0] byte_count_ff, byte_count_in;
   logic             overflowed_ff, overflowed_in;
   logic [ByteW-1:0] run_dec;
   logic             is_delim;

   assign is_delim = (item.in_byte == DelimByte);
   assign run_dec  = run_count_ff - 8'd1;

   always_comb begin
      in_frame_in   = in_frame_ff;
      run_count_in  = run_count_ff;
      byte_count_in = byte_count_ff;
      overflowed_in = overflowed_ff;
      step_out      = '0;
      if (!in_frame_ff) begin
         // Code byte opens a frame; idle delimiters are dropped.
         if (!is_delim) begin
            in_frame_in   = 1'b1;
            run_count_in  = item.in_byte;
            byte_count_in = '0;
            overflowed_in = 1'b0;
         end
      end else if (is_delim) begin
         step_out.valid             = 1'b1;
         step_out.data.frame_end    = 1'b1;
         step_out.data.frame_length = byte_count_ff;
         step_out.data.overflow     = overflowed_ff;
         in_frame_in                = 1'b0;
         byte_count_in              = '0;
         overflowed_in              = 1'b0;
      end else begin
         if (run_dec == '0) begin
            run_count_in           = item.in_byte;
            step_out.data.out_byte = DelimByte;
         end else begin
            run_count_in           = run_dec;
            step_out.data.out_byte = item.in_byte;
         end
         if (byte_count_ff >= MaxLenB) begin
            // Saturate and drop the byte.
            byte_count_in = MaxLenB;
            overflowed_in = 1'b1;
         end else begin
            byte_count_in  = byte_count_ff + 8'd1;
            step_out.valid = 1'b1;
         end
      end
   end

   // A byte with no result never waits on the output side.
   assign take = item.valid && (!step_out.valid || out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         run_count_ff  <= '0;
         byte_count_ff <= '0;
         overflowed_ff <= 1'b0;
      end else if (take) begin
         in_frame_ff   <= in_frame_in;
         run_count_ff  <= run_count_in;
         byte_count_ff <= byte_count_in;
         overflowed_ff <= overflowed_in;
      end
   end

endmodule

// File: hw/rtl/cfd_out_stage.sv
module cfd_out_stage import cfd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfd_step_out_type step_out,
   input  logic             take,
   input  logic             rsp_ready,
   output logic             out_free,
   output logic             rsp_valid,
   output cfd_result_type   rsp_data
);

   logic           valid_ff;
   logic           valid_in;
   cfd_result_type data_ff;

   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = out_free ? (step_out.valid && take) : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && take && step_out.valid) begin
         data_ff <= step_out.data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: hw/rtl/cobs_frame_decoder_unit.sv
// Streaming COBS deframer, one received byte per transfer.
// A byte waits in the input register and its result in the output register before being offered.
// Throughput: one byte per cycle unless a result stalls on a full output register.
// Run and length update is one compare and decrement; no-result bytes still pass the input register.
// Reset (synchronous, active high) empties both registers and returns the deframer to idle.
`include "cobs_frame_decoder_unit_assert.svh"

module cobs_frame_decoder_unit import cfd_pkg::*; #(
   parameter int unsigned MAX_LEN = 254
) (
   input logic       clock,
   input logic       reset,
   cfd_req_if.sink   req_chan,
   cfd_rsp_if.source rsp_chan
);

   cfd_item_type     item;
   cfd_step_out_type step_out;
   cfd_result_type   rsp_data;
   logic             take;
   logic             out_free;

   cfd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_in_byte (req_chan.in_byte),
      .req_ready   (req_chan.ready),
      .take        (take),
      .item        (item)
   );

   cfd_step #(
      .MAX_LEN (MAX_LEN)
   ) u_step (
      .clock    (clock),
      .reset    (reset),
      .item     (item),
      .out_free (out_free),
      .take     (take),
      .step_out (step_out)
   );

   cfd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .step_out  (step_out),
      .take      (take),
      .rsp_ready (rsp_chan.ready),
      .out_free  (out_free),
      .rsp_valid (rsp_chan.valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_chan.out_byte     = rsp_data.out_byte;
   assign rsp_chan.frame_end    = rsp_data.frame_end;
   assign rsp_chan.frame_length = rsp_data.frame_length;
   assign rsp_chan.overflow     = rsp_data.overflow;

   `CFD_ASSERT_NOW(a_end_fields, clock, reset, rsp_chan.valid && rsp_chan.frame_end, rsp_chan.out_byte == DelimByte)
   `CFD_ASSERT_NOW(a_data_fields, clock, reset, rsp_chan.valid && !rsp_chan.frame_end, rsp_chan.frame_length == '0 && !rsp_chan.overflow)
   `CFD_ASSERT_NOW(a_ovf_saturated, clock, reset, rsp_chan.valid && rsp_chan.overflow, rsp_chan.frame_length == ByteW'(MAX_LEN))
   `CFD_ASSERT_NEXT(a_result_loaded, clock, reset, take && step_out.valid, rsp_chan.valid)

endmodule

// File: verif/tb.sv
module tb;
   import cfd_pkg::*;

   localparam int unsigned MAX_LEN        = 254;
   localparam int          RANDOM_ITEMS   = 1225;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          DRAIN_CYCLES   = 8;
   localparam int          WATCHDOG_LIMIT = 5000;
   localparam int          REPORT_LIMIT   = 10;

   typedef enum logic [1:0] {
      CHK_PRED,
      CHK_NONE,
      CHK_FIXED
   } chk_type;

   typedef struct {
      logic [ByteW-1:0] in_byte;
      chk_type          chk;
      cfd_result_type   res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cfd_req_if req_chan ();
   cfd_rsp_if rsp_chan ();

   cobs_frame_decoder_unit #(
      .MAX_LEN(MAX_LEN)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #1 clock = ~clock;

   // Deframer state mirrored on the accepted byte stream
   logic             dec_in_frame = 1'b0;
   logic [ByteW-1:0] dec_run      = '0;
   logic [ByteW-1:0] dec_len      = '0;
   logic             dec_ovf      = 1'b0;

   cfd_result_type   pending_decodes[$];
   logic [ByteW-1:0] tx_bytes[$];
   stim_row_type     directed[$];

   // Tag of the byte on offer, moved with the byte itself
   chk_type          pin_chk = CHK_PRED;
   cfd_result_type   pin_res = '0;

   cfd_result_type   pred_res;
   bit               pred_has;
   cfd_result_type   got_res;
   cfd_result_type   want_res;

   int  mismatches   = 0;
   int  bytes_in     = 0;
   int  results_seen = 0;
   int  frames_seen  = 0;
   int  ovf_frames   = 0;
   int  idle_cycles  = 0;
   int  stim_count   = 0;
   int  burst_left   = 0;
   bit  hold_rsp     = 1'b0;

   function automatic bit deframe_byte(input logic [ByteW-1:0] b, output cfd_result_type r);
      logic [ByteW-1:0] dec;
      r = '0;
      if (!dec_in_frame) begin
         // a delimiter while idle changes nothing; a code byte opens a frame
         if (b != DelimByte) begin
            dec_run      = b;
            dec_len      = '0;
            dec_ovf      = 1'b0;
            dec_in_frame = 1'b1;
         end
         return 1'b0;
      end
      if (b == DelimByte) begin
         r.frame_end    = 1'b1;
         r.frame_length = dec_len;
         r.overflow     = dec_ovf;
         dec_in_frame   = 1'b0;
         dec_len        = '0;
         dec_ovf        = 1'b0;
         return 1'b1;
      end
      dec_run = dec_run - 1'b1;
      if (dec_run == '0) begin
         dec     = DelimByte;
         dec_run = b;
      end else begin
         dec = b;
      end
      // past the length limit: advance the run counter, drop the byte
      if (dec_len >= MAX_LEN) begin
         dec_len = ByteW'(MAX_LEN);
         dec_ovf = 1'b1;
         return 1'b0;
      end
      dec_len    = dec_len + 1'b1;
      r.out_byte = dec;
      return 1'b1;
   endfunction

   function automatic cfd_result_type data_res(input logic [ByteW-1:0] b);
      cfd_result_type r;
      r          = '0;
      r.out_byte = b;
      return r;
   endfunction

   function automatic cfd_result_type end_res(input logic [ByteW-1:0] len, input logic ovf);
      cfd_result_type r;
      r              = '0;
      r.frame_end    = 1'b1;
      r.frame_length = len;
      r.overflow     = ovf;
      return r;
   endfunction

   function automatic stim_row_type stim_row(input logic [ByteW-1:0] b, input chk_type c,
                                             input cfd_result_type r);
      stim_row_type s;
      s.in_byte = b;
      s.chk     = c;
      s.res     = r;
      return s;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string what, input cfd_result_type want,
                                  input cfd_result_type got);
      if (mismatches < REPORT_LIMIT)
         $display("%s: want byte %02h end %0d len %0d ovf %0d, got byte %02h end %0d len %0d ovf %0d",
                  what, want.out_byte, want.frame_end, want.frame_length, want.overflow,
                  got.out_byte, got.frame_end, got.frame_length, got.overflow);
      mismatches++;
   endtask

   task automatic send_byte(input logic [ByteW-1:0] b, input chk_type c, input cfd_result_type r);
      int gap;
      gap = (burst_left > 0) ? 0 : pick_gap();
      if (burst_left > 0) burst_left--;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      pin_chk          <= c;
      pin_res          <= r;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Encode random data as one COBS frame, optionally damaging one byte
   task automatic queue_frame(input int len, input bit corrupt);
      logic [ByteW-1:0] grp[$];
      logic [ByteW-1:0] d;
      int               nz;
      int               start;
      int               i;
      nz    = 0;
      start = tx_bytes.size();
      for (i = 0; i < len; i++) begin
         d = ($urandom_range(0, 3) == 0) ? DelimByte : ByteW'($urandom_range(1, 255));
         // keep groups short enough that the code byte never wraps
         if (nz == 200) d = DelimByte;
         if (d == DelimByte) begin
            tx_bytes.push_back(ByteW'(grp.size() + 1));
            foreach (grp[j]) tx_bytes.push_back(grp[j]);
            grp.delete();
            nz = 0;
         end else begin
            grp.push_back(d);
            nz++;
         end
      end
      tx_bytes.push_back(ByteW'(grp.size() + 1));
      foreach (grp[j]) tx_bytes.push_back(grp[j]);
      tx_bytes.push_back(DelimByte);
      if (corrupt)
         tx_bytes[$urandom_range(start, tx_bytes.size() - 1)] = ByteW'($urandom_range(0, 255));
      stim_count += tx_bytes.size() - start;
   endtask

   task automatic queue_noise();
      logic [ByteW-1:0] d;
      int               n;
      int               r;
      n = $urandom_range(1, 12);
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 30)      d = DelimByte;
         else if (r < 40) d = 8'hFF;
         else             d = ByteW'($urandom_range(0, 255));
         tx_bytes.push_back(d);
         if (d != DelimByte) stim_count++;
      end
   endtask

   // Input side: predict on every transfer
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         bytes_in++;
         pred_has = deframe_byte(req_chan.in_byte, pred_res);
         case (pin_chk)
            CHK_NONE:  ;
            CHK_FIXED: pending_decodes.push_back(pin_res);
            default:   if (pred_has) pending_decodes.push_back(pred_res);
         endcase
      end
   end

   // Result side: compare against the oldest pending decode
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got_res.out_byte     = rsp_chan.out_byte;
         got_res.frame_end    = rsp_chan.frame_end;
         got_res.frame_length = rsp_chan.frame_length;
         got_res.overflow     = rsp_chan.overflow;
         results_seen++;
         if (got_res.frame_end === 1'b1) frames_seen++;
         if (got_res.frame_end === 1'b1 && got_res.overflow === 1'b1) ovf_frames++;
         if (pending_decodes.size() == 0) begin
            report_mismatch("unexpected result", '0, got_res);
         end else begin
            want_res = pending_decodes.pop_front();
            if (got_res.out_byte !== want_res.out_byte ||
                got_res.frame_end !== want_res.frame_end ||
                got_res.frame_length !== want_res.frame_length ||
                got_res.overflow !== want_res.overflow)
               report_mismatch("result mismatch", want_res, got_res);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("watchdog: no transfer for %0d cycles, %0d decodes pending",
               WATCHDOG_LIMIT, pending_decodes.size());
      $display("** cobs_frame_decoder_unit: FAILED **");
      $finish;
   end

   // Receiver: random back-pressure, plus one long hold when asked
   initial begin
      int on_len;
      int off_len;
      rsp_chan.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 16);
         rsp_chan.ready <= 1'b1;
         repeat (on_len) @(posedge clock);
         off_len = pick_gap();
         if (off_len > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (off_len) @(posedge clock);
         end
      end
   end

   initial begin
      logic [ByteW-1:0] b;
      int               frame_no;
      int               len;

      req_chan.valid   = 1'b0;
      req_chan.in_byte = '0;

      directed.push_back(stim_row(8'h00, CHK_NONE,  '0));            // delimiter while idle
      directed.push_back(stim_row(8'h00, CHK_NONE,  '0));
      directed.push_back(stim_row(8'h01, CHK_NONE,  '0));            // code byte
      directed.push_back(stim_row(8'h00, CHK_FIXED, end_res(8'd0, 1'b0)));   // empty frame
      directed.push_back(stim_row(8'h03, CHK_NONE,  '0));
      directed.push_back(stim_row(8'h11, CHK_PRED,  '0));
      directed.push_back(stim_row(8'h22, CHK_PRED,  '0));
      directed.push_back(stim_row(8'h05, CHK_FIXED, data_res(8'h00)));
      directed.push_back(stim_row(8'hFF, CHK_PRED,  '0));
      directed.push_back(stim_row(8'h00, CHK_FIXED, end_res(8'd4, 1'b0)));
      directed.push_back(stim_row(8'hFF, CHK_NONE,  '0));            // code 0xFF, no special group
      directed.push_back(stim_row(8'h80, CHK_PRED,  '0));
      directed.push_back(stim_row(8'h7F, CHK_PRED,  '0));
      directed.push_back(stim_row(8'h01, CHK_PRED,  '0));
      directed.push_back(stim_row(8'h00, CHK_FIXED, end_res(8'd3, 1'b0)));
      directed.push_back(stim_row(8'h01, CHK_NONE,  '0));            // run of one: zero every byte
      directed.push_back(stim_row(8'h01, CHK_FIXED, data_res(8'h00)));
      directed.push_back(stim_row(8'h01, CHK_FIXED, data_res(8'h00)));
      directed.push_back(stim_row(8'hFF, CHK_FIXED, data_res(8'h00)));
      directed.push_back(stim_row(8'h00, CHK_FIXED, end_res(8'd3, 1'b0)));
      directed.push_back(stim_row(8'h02, CHK_NONE,  '0));
      directed.push_back(stim_row(8'hAA, CHK_PRED,  '0));
      directed.push_back(stim_row(8'h55, CHK_FIXED, data_res(8'h00)));
      directed.push_back(stim_row(8'h00, CHK_FIXED, end_res(8'd2, 1'b0)));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_byte(directed[i].in_byte, directed[i].chk, directed[i].res);

      frame_no = 0;
      while (stim_count < RANDOM_ITEMS) begin
         // stall the receiver while the sender keeps offering back to back
         if (frame_no == 3) begin
            hold_rsp   = 1'b1;
            burst_left = 400;
         end
         if (frame_no < 12 || $urandom_range(0, 99) < 85) begin
            if (frame_no == 2)                 len = MAX_LEN;
            else if (frame_no == 5)            len = MAX_LEN + 1;
            else if (frame_no == 9)            len = MAX_LEN + 8;
            else if ($urandom_range(0, 99) < 3) len = $urandom_range(240, 270);
            else                               len = $urandom_range(0, 24);
            if ($urandom_range(0, 1) == 0) tx_bytes.push_back(DelimByte);
            queue_frame(len, frame_no > 12 && $urandom_range(0, 9) == 0);
         end else begin
            queue_noise();
         end
         while (tx_bytes.size() > 0) begin
            b = tx_bytes.pop_front();
            send_byte(b, CHK_PRED, '0);
         end
         frame_no++;
      end

      req_chan.valid <= 1'b0;
      while (pending_decodes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_decodes.size() != 0) begin
         $display("%0d decodes never arrived", pending_decodes.size());
         mismatches += pending_decodes.size();
      end

      $display("Fed %0d encoded bytes in %0d chunks; checked %0d decoded results",
               bytes_in, frame_no, results_seen);
      $display("Frame ends seen: %0d, of which %0d overflowed; mismatches: %0d",
               frames_seen, ovf_frames, mismatches);
      if (mismatches == 0)
         $display("** cobs_frame_decoder_unit: PASSED **");
      else
         $display("** cobs_frame_decoder_unit: FAILED **");
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/cfd_pkg.sv
hw/rtl/cfd_if.sv
hw/rtl/cfd_in_stage.sv
hw/rtl/cfd_step.sv
hw/rtl/cfd_out_stage.sv
hw/rtl/cobs_frame_decoder_unit.sv
verif/tb.sv
